// ----- sv/sha224_sha256_hash_engine_assert.svh -----
// Assertion macros for the SHA-224/256 hash engine.
// Included by the modules that carry concurrent checks.
`ifndef SHA224_SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA224_SHA256_HASH_ENGINE_ASSERT_SVH

// Check that a property holds on every clock edge outside reset.
`define SHE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`endif

// ----- sv/she_pkg.sv -----
// Package for the SHA-224/256 hash engine: round constants, initial hash values,
// controller state type and command/status structs. No dependencies.
`timescale 1ns / 1ps
package she_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ZERO,
		ST_LEN,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} she_state_t;

	typedef struct packed {
		logic absorb;       // write input byte at current position
		logic put_pad;      // write 0x80 at current position
		logic put_len;      // write bit count into words 14 and 15
		logic comp_start;   // load working vars, start round counter
		logic round;        // run one round
		logic comp_fold;    // add working vars into chaining value, clear block
		logic restart;      // reload initial hash value, clear position and count
	} she_cmd_t;

	typedef struct packed {
		logic       block_full;  // position at 63: the next absorb fills the block
		logic       pad_spill;   // position after 0x80 is past 56
		logic       round_last;  // round counter at 63
	} she_status_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] IV_256 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] IV_224 [8] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam int unsigned WORDS_256 = 8;
	localparam int unsigned WORDS_224 = 7;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- sv/she_if.sv -----
// Valid/ready channel interfaces for the SHA-224/256 hash engine.
// No dependencies.
`timescale 1ns / 1ps
interface she_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last;
	modport source (output valid, data_byte, byte_valid, last, input ready);
	modport sink (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface she_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- sv/she_datapath.sv -----
// Datapath: block buffer, message schedule, round unit, chaining value, bit count.
// Depends on she_pkg.
`timescale 1ns / 1ps
module she_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  she_pkg::she_cmd_t    cmd,
	output she_pkg::she_status_t status,
	input  logic                 mode,
	input  logic [7:0]           data_byte,
	input  logic [2:0]           rd_index,
	output logic [31:0]          rd_word
);
	import she_pkg::*;

	logic [31:0] blk_q [16];   // block buffer, reused as schedule window
	logic [31:0] cv_q [8];
	logic [31:0] v_q [8];
	logic [5:0]  pos_q;
	logic [63:0] count_q;
	logic [5:0]  rnd_q;

	logic [31:0] w_t, w_new, s0, s1, t1, t2, sig1, sig0, ch, maj;
	logic [1:0]  sub;
	logic [3:0]  widx;
	logic [4:0]  sh;
	logic [31:0] ins_byte;
	logic        ins;

	// Schedule window: blk_q[0] is w[t]; shift left each round.
	assign w_t = blk_q[0];
	assign s0 = rotr(blk_q[1], 7) ^ rotr(blk_q[1], 18) ^ (blk_q[1] >> 3);
	assign s1 = rotr(blk_q[14], 17) ^ rotr(blk_q[14], 19) ^ (blk_q[14] >> 10);
	assign w_new = blk_q[0] + s0 + blk_q[9] + s1;

	assign sig1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1 = v_q[7] + sig1 + ch + ROUND_K[rnd_q] + w_t;
	assign sig0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t2 = sig0 + maj;

	assign sub = pos_q[1:0];
	assign widx = pos_q[5:2];
	assign sh = {~sub, 3'b000};
	assign ins = cmd.absorb || cmd.put_pad;
	assign ins_byte = {24'd0, cmd.put_pad ? PAD_BYTE : data_byte} << sh;

	assign status.block_full = (pos_q == 6'd63);
	assign status.pad_spill = (pos_q > LEN_POS - 6'd1);
	assign status.round_last = (rnd_q == 6'd63);
	assign rd_word = cv_q[rd_index];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			count_q <= '0;
			rnd_q <= '0;
			for (int i = 0; i < 16; i++) blk_q[i] <= '0;
			for (int i = 0; i < 8; i++) cv_q[i] <= IV_256[i];
			for (int i = 0; i < 8; i++) v_q[i] <= '0;
		end else begin
			if (ins) begin
				// bytes after pos are always zero, so OR suffices
				blk_q[widx] <= blk_q[widx] | ins_byte;
				pos_q <= pos_q + 6'd1;
				if (cmd.absorb) count_q <= count_q + 64'd8;
			end
			if (cmd.put_len) begin
				blk_q[14] <= count_q[63:32];
				blk_q[15] <= count_q[31:0];
			end
			if (cmd.comp_start) begin
				rnd_q <= '0;
				for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
			end
			if (cmd.round) begin
				rnd_q <= rnd_q + 6'd1;
				for (int i = 0; i < 15; i++) blk_q[i] <= blk_q[i + 1];
				blk_q[15] <= w_new;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			if (cmd.comp_fold) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + v_q[i];
				for (int i = 0; i < 16; i++) blk_q[i] <= '0;
				pos_q <= '0;
			end
			if (cmd.restart) begin
				for (int i = 0; i < 8; i++) cv_q[i] <= mode ? IV_224[i] : IV_256[i];
				for (int i = 0; i < 16; i++) blk_q[i] <= '0;
				pos_q <= '0;
				count_q <= '0;
			end
		end
	end

endmodule

// ----- sv/she_ctrl.sv -----
// Controller FSM: sequences absorb, padding, compression rounds and digest output.
// Depends on she_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "sha224_sha256_hash_engine_assert.svh"
module she_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 byte_valid,
	input  logic                 last,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 mode,
	input  logic                 cfg_we,
	input  she_pkg::she_status_t status,
	output she_pkg::she_cmd_t    cmd,
	output logic [2:0]           word_index,
	output logic                 last_word
);
	import she_pkg::*;

	she_state_t state_q, state_d;
	logic       fin_q, fin_d;     // compression belongs to the final block
	logic       spill_q, spill_d; // padding needs a second block
	logic       lenp_q, lenp_d;   // spilled block done, length block next
	logic [2:0] widx_q, widx_d;
	logic       acc;

	assign in_ready = (state_q == ST_IDLE);
	assign acc = in_valid && in_ready;
	assign out_valid = (state_q == ST_EMIT);
	assign word_index = widx_q;
	assign last_word = mode ? (widx_q == 3'(WORDS_224 - 1)) : (widx_q == 3'(WORDS_256 - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q <= 1'b0;
			spill_q <= 1'b0;
			lenp_q <= 1'b0;
			widx_q <= '0;
		end else begin
			state_q <= state_d;
			fin_q <= fin_d;
			spill_q <= spill_d;
			lenp_q <= lenp_d;
			widx_q <= widx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		fin_d = fin_q;
		spill_d = spill_q;
		lenp_d = lenp_q;
		widx_d = widx_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.restart = cfg_we;
				if (acc) begin
					cmd.absorb = byte_valid;
					if (byte_valid && status.block_full) begin
						cmd.comp_start = 1'b1;
						fin_d = 1'b0;
						state_d = ST_ROUND;
						// full-block compression first, then padding
						spill_d = last;
					end else if (last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				cmd.put_pad = 1'b1;
				spill_d = 1'b0;
				state_d = status.pad_spill ? ST_ZERO : ST_LEN;
			end
			ST_ZERO: begin
				// tail already zero: compress the spilled block as is
				cmd.comp_start = 1'b1;
				fin_d = 1'b0;
				lenp_d = 1'b1;
				state_d = ST_ROUND;
			end
			ST_LEN: begin
				cmd.put_len = 1'b1;
				cmd.comp_start = 1'b1;
				fin_d = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (status.round_last) state_d = ST_FINAL;
			end
			ST_FINAL: begin
				cmd.comp_fold = 1'b1;
				widx_d = '0;
				if (fin_q) begin
					state_d = ST_EMIT;
				end else if (spill_q) begin
					state_d = ST_PAD;
				end else if (lenp_q) begin
					lenp_d = 1'b0;
					state_d = ST_LEN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_ready) begin
					widx_d = widx_q + 3'd1;
					if (last_word) begin
						cmd.restart = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`SHE_ASSERT(a_ready_only_idle, in_ready |-> !out_valid, "ready while emitting")
	`SHE_ASSERT(a_emit_after_final, $rose(out_valid) |-> $past(state_q == ST_FINAL && fin_q),
		"digest without final block")
	`SHE_ASSERT(a_first_word_zero, $rose(out_valid) |-> word_index == 3'd0,
		"digest does not start at word 0")
	`SHE_ASSERT(a_rounds_64, (state_q == ST_FINAL) |-> $past(status.round_last),
		"fold without 64 rounds")

endmodule

// ----- sv/sha224_sha256_hash_engine.sv -----
// SHA-224/256 hash engine top level: controller, datapath and mode register.
// Depends on she_pkg, she_if, she_ctrl and she_datapath.
`timescale 1ns / 1ps
// Takes one message byte per transfer on the input channel and returns the digest as 32-bit
// words (8 for SHA-256, 7 for SHA-224 when the mode bit is 1). Bytes are accepted only while
// idle; the 64th byte of a block starts the one-round-per-cycle compression unit, and no
// input is taken until it is done. A last byte adds padding and one or two compressions,
// then one digest word per cycle while out_ready is high on the output channel. A mode
// write in idle reloads the initial hash value and drops any partial message.
module sha224_sha256_hash_engine (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic    cfg_wdata,
	she_in_if.sink  in_ch,
	she_out_if.source out_ch
);
	import she_pkg::*;

	logic        mode_q;
	she_cmd_t    cmd;
	she_status_t status;
	logic [2:0]  widx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	she_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.byte_valid (in_ch.byte_valid),
		.last       (in_ch.last),
		.in_ready   (in_ch.ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.mode       (mode_q),
		.cfg_we     (cfg_we),
		.status     (status),
		.cmd        (cmd),
		.word_index (widx),
		.last_word  (out_ch.last_word)
	);

	she_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.mode      (cfg_we ? cfg_wdata : mode_q),
		.data_byte (in_ch.data_byte),
		.rd_index  (widx),
		.rd_word   (out_ch.digest_word)
	);

	assign out_ch.word_index = widx;

endmodule
